FILE: rtl/vgh_pkg.sv
`default_nettype none

package vgh_pkg;

    // Fixed field widths.
    localparam int COORD_W = 6;
    localparam int TILE_W  = 8;
    localparam int CMD_W   = 2;
    localparam int CFG_W   = 7;
    localparam int IDX_W   = 2;

    // Command codes. Every code other than set tile is a query that changes nothing.
    localparam logic [CMD_W-1:0] CMD_SET = 2'd0;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // Size that every axis takes after reset, before clamping.
    localparam int SIZE_RESET = 64;

    // Bits of the column word examined per cycle by the height search.
    localparam int SCAN_CHUNK = 16;

    // floor(v / 3) = (v * 683) >> 11 for every v below 2048.
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [TILE_W-1:0]  tile_type;
    } cmd_beat_t;

    typedef struct packed {
        logic               in_range;
        logic               is_tile;
        logic               is_dark;
        logic [COORD_W-1:0] dirty_x_low;
        logic [COORD_W-1:0] dirty_y_low;
        logic [COORD_W-1:0] dirty_z_low;
    } rsp_beat_t;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] dy;
    } scan_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/vgh_col_mem.sv
`default_nettype none

module vgh_col_mem
    import vgh_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 64,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/vgh_fill.sv
`default_nettype none

module vgh_fill
    import vgh_pkg::*;
#(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64,
    localparam int SXW = $clog2(MAX_X + 1),
    localparam int SYW = $clog2(MAX_Y + 1),
    localparam int SZW = $clog2(MAX_Z + 1),
    localparam int AW  = $clog2(MAX_X * MAX_Z)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             restart,
    input  wire logic [SXW-1:0]   size_x,
    input  wire logic [SYW-1:0]   size_y,
    input  wire logic [SZW-1:0]   size_z,
    output logic                  busy,
    output logic                  wr_en,
    output logic      [AW-1:0]    wr_addr,
    output logic      [MAX_Y-1:0] wr_data
);

    localparam int XW    = $clog2(MAX_X);
    localparam int ZW    = $clog2(MAX_Z);
    localparam int NCOLS = MAX_X * MAX_Z;
    localparam int PRW   = SYW + 1 + 12;

    logic          busy_reg, busy_next;
    logic [XW-1:0] cx_reg, cx_next;
    logic [ZW-1:0] cz_reg, cz_next;
    logic [AW-1:0] addr_reg, addr_next;

    logic [PRW-1:0] ground_prod;
    logic [SYW-1:0] ground;
    logic           col_inside;

    // Ground level is floor(2 * size_y / 3), done as a reciprocal multiply.
    assign ground_prod = PRW'({size_y, 1'b0}) * PRW'(DIV3_MUL);
    assign ground      = SYW'(ground_prod >> DIV3_SHIFT);

    assign col_inside = (SXW'(cx_reg) < size_x) && (SZW'(cz_reg) < size_z);

    // Ground fill column word: solid from y 0 to the ground level inside the sizes.
    always_comb
    begin
        for (int i = 0; i < MAX_Y; i++)
        begin
            wr_data[i] = col_inside && (SYW'(i) <= ground);
        end
    end

    // Sweep every column once, one column per cycle; a restart begins again at zero.
    always_comb
    begin
        busy_next = busy_reg;
        cx_next   = cx_reg;
        cz_next   = cz_reg;
        addr_next = addr_reg;
        if (restart)
        begin
            busy_next = 1'b1;
            cx_next   = '0;
            cz_next   = '0;
            addr_next = '0;
        end
        else if (busy_reg)
        begin
            addr_next = addr_reg + 1'b1;
            if (32'(cx_reg) == MAX_X - 1)
            begin
                cx_next = '0;
                cz_next = cz_reg + 1'b1;
            end
            else
            begin
                cx_next = cx_reg + 1'b1;
            end
            if (32'(addr_reg) == NCOLS - 1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cx_reg   <= '0;
            cz_reg   <= '0;
            addr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cx_reg   <= cx_next;
            cz_reg   <= cz_next;
            addr_reg <= addr_next;
        end
    end

    assign busy    = busy_reg;
    assign wr_en   = busy_reg;
    assign wr_addr = addr_reg;

endmodule

`default_nettype wire

FILE: rtl/vgh_scan.sv
`default_nettype none

module vgh_scan
    import vgh_pkg::*;
#(
    parameter int MAX_Y = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MAX_Y-1:0] word,
    output scan_rsp_t             rsp
);

    localparam int NCH = (MAX_Y + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int PW  = NCH * SCAN_CHUNK;
    localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IW  = $clog2(SCAN_CHUNK);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [PW-1:0]          word_reg, word_next;
    logic [COORD_W-1:0]     dy_reg, dy_next;

    logic [SCAN_CHUNK-1:0]  top_chunk;
    logic                   hit;
    logic [IW-1:0]          idx;

    // The chunk under test always sits at the top of the shifted word.
    assign top_chunk = word_reg[PW-1 -: SCAN_CHUNK];
    assign hit       = |top_chunk;

    // Highest set bit within the chunk.
    always_comb
    begin
        idx = '0;
        for (int j = 0; j < SCAN_CHUNK; j++)
        begin
            if (top_chunk[j])
            begin
                idx = IW'(j);
            end
        end
    end

    // Walk the chunks from the top down and stop at the first one with a set bit, or at the lowest.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        word_next = word_reg;
        dy_next   = dy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = KW'(NCH - 1);
            word_next = PW'(word);
        end
        else if (busy_reg)
        begin
            if (hit || (k_reg == '0))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                dy_next   = hit ? COORD_W'(int'(k_reg) * SCAN_CHUNK + int'(idx))
                                : '0;
            end
            else
            begin
                word_next = word_reg << SCAN_CHUNK;
                k_next    = k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        word_reg <= word_next;
        dy_reg   <= dy_next;
    end

    assign rsp.done = done_reg;
    assign rsp.dy   = dy_reg;

endmodule

`default_nettype wire

FILE: rtl/voxel_grid_with_column_heightmap_top.sv
`default_nettype none

// Voxel grid with a per-column light depth. Each (x, z) column is one word of
// occupancy bits in a single-port-write, registered-read memory; a voxel is
// solid when its bit is set, and the light depth is taken from the bits above
// the addressed y, so no separate tile or depth store is kept. Items are worked
// one at a time: a query passes from acceptance to the result beat through
// accept and memory read, modify and result register, and a set tile adds the
// chunked search for the highest solid y below the written voxel, 16 bits
// of the column word per cycle. After reset and after every size write the
// grid is refilled with the ground fill by a sweep over all MAX_X * MAX_Z
// columns, one column per cycle, during which no command beat is accepted.
// A result beat may wait on the output while the next command is already taken.
module voxel_grid_with_column_heightmap_top
    import vgh_pkg::*;
#(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire cmd_beat_t        cmd_beat,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output rsp_beat_t             rsp_beat,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int SXW   = $clog2(MAX_X + 1);
    localparam int SYW   = $clog2(MAX_Y + 1);
    localparam int SZW   = $clog2(MAX_Z + 1);
    localparam int NCOLS = MAX_X * MAX_Z;
    localparam int AW    = $clog2(NCOLS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    function automatic int clamp_size(int v, int maxv);
        int r;
        r = v;
        if (v < 1)
        begin
            r = 1;
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    // Configuration registers.
    logic [SXW-1:0] size_x_reg, size_x_next;
    logic [SYW-1:0] size_y_reg, size_y_next;
    logic [SZW-1:0] size_z_reg, size_z_next;
    logic           cfg_restart;

    // Control.
    logic [1:0]     state_reg, state_next;
    logic           rsp_valid_reg, rsp_valid_next;

    // Payload.
    cmd_beat_t      item_reg, item_next;
    logic [AW-1:0]  col_reg, col_next;
    logic           range_reg, range_next;
    logic           tile_reg, tile_next;
    logic           dark_reg, dark_next;
    logic [COORD_W-1:0] dy_reg, dy_next;
    rsp_beat_t      rsp_reg, rsp_next;

    // Memory and helpers.
    logic             cmd_accept;
    logic             cmd_in_range;
    logic [AW-1:0]    cmd_col;
    logic             fill_busy;
    logic             fill_wr_en;
    logic [AW-1:0]    fill_wr_addr;
    logic [MAX_Y-1:0] fill_wr_data;
    logic             cmd_wr_en;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [MAX_Y-1:0] mem_wr_data;
    logic [MAX_Y-1:0] rd_word;
    logic [MAX_Y-1:0] eq_mask, above_mask, below_mask;
    logic [MAX_Y-1:0] new_word;
    logic             is_set;
    logic             upd_tile, upd_dark;
    logic             scan_start;
    scan_rsp_t        scan_rsp;

    // Size writes are clamped to 1..MAX of the axis and start a ground refill.
    always_comb
    begin
        size_x_next = size_x_reg;
        size_y_next = size_y_reg;
        size_z_next = size_z_reg;
        cfg_restart = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SIZE_X:
                begin
                    size_x_next = SXW'(clamp_size(int'(cfg_data), MAX_X));
                    cfg_restart = 1'b1;
                end
                REG_SIZE_Y:
                begin
                    size_y_next = SYW'(clamp_size(int'(cfg_data), MAX_Y));
                    cfg_restart = 1'b1;
                end
                REG_SIZE_Z:
                begin
                    size_z_next = SZW'(clamp_size(int'(cfg_data), MAX_Z));
                    cfg_restart = 1'b1;
                end
                default:
                begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
    end

    // Command beats enter only when the block is idle, the grid is filled and no register write is under way.
    assign cmd_stall  = (state_reg != S_IDLE) || fill_busy || cfg_we;
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign cmd_in_range = (32'(cmd_beat.pos_x) < 32'(size_x_reg))
                       && (32'(cmd_beat.pos_y) < 32'(size_y_reg))
                       && (32'(cmd_beat.pos_z) < 32'(size_z_reg));
    assign cmd_col = AW'(32'(cmd_beat.pos_z) * MAX_X + 32'(cmd_beat.pos_x));

    // Bit masks for the addressed y: the voxel itself, the bits above it, and
    // the bits from 1 up to just below it.
    always_comb
    begin
        for (int i = 0; i < MAX_Y; i++)
        begin
            eq_mask[i]    = (i == int'(item_reg.pos_y));
            above_mask[i] = (i > int'(item_reg.pos_y));
            below_mask[i] = (i >= 1) && (i < int'(item_reg.pos_y));
        end
    end

    // Modify the column word read for this item.
    assign is_set   = (item_reg.command == CMD_SET);
    assign new_word = is_set ? ((rd_word & ~eq_mask)
                               | (eq_mask & {MAX_Y{item_reg.tile_type != '0}}))
                             : rd_word;
    assign upd_tile = |(new_word & eq_mask);
    assign upd_dark = |(new_word & above_mask);

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        item_next      = item_reg;
        col_next       = col_reg;
        range_next     = range_reg;
        tile_next      = tile_reg;
        dark_next      = dark_reg;
        dy_next        = dy_reg;
        rsp_next       = rsp_reg;
        cmd_wr_en      = 1'b0;
        scan_start     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    item_next  = cmd_beat;
                    col_next   = cmd_col;
                    range_next = cmd_in_range;
                    if (cmd_in_range)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        tile_next  = 1'b0;
                        dark_next  = 1'b0;
                        dy_next    = '0;
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                tile_next = upd_tile;
                dark_next = upd_dark;
                dy_next   = '0;
                if (is_set)
                begin
                    cmd_wr_en  = 1'b1;
                    scan_start = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    dy_next    = scan_rsp.dy;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.in_range    = range_reg;
                    rsp_next.is_tile     = tile_reg;
                    rsp_next.is_dark     = dark_reg;
                    rsp_next.dirty_y_low = dy_reg;
                    rsp_next.dirty_x_low = '0;
                    rsp_next.dirty_z_low = '0;
                    if (range_reg && is_set)
                    begin
                        rsp_next.dirty_x_low = (item_reg.pos_x != '0)
                                             ? item_reg.pos_x - 1'b1 : '0;
                        rsp_next.dirty_z_low = (item_reg.pos_z != '0)
                                             ? item_reg.pos_z - 1'b1 : '0;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg    <= SXW'(clamp_size(SIZE_RESET, MAX_X));
            size_y_reg    <= SYW'(clamp_size(SIZE_RESET, MAX_Y));
            size_z_reg    <= SZW'(clamp_size(SIZE_RESET, MAX_Z));
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            size_x_reg    <= size_x_next;
            size_y_reg    <= size_y_next;
            size_z_reg    <= size_z_next;
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        col_reg   <= col_next;
        range_reg <= range_next;
        tile_reg  <= tile_next;
        dark_reg  <= dark_next;
        dy_reg    <= dy_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_reg;

    // The refill sweep owns the write port while it runs.
    assign mem_wr_en   = fill_wr_en || cmd_wr_en;
    assign mem_wr_addr = fill_wr_en ? fill_wr_addr : col_reg;
    assign mem_wr_data = fill_wr_en ? fill_wr_data : new_word;

    vgh_col_mem #(
        .DEPTH (NCOLS),
        .WIDTH (MAX_Y)
    ) u_col_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (cmd_accept && cmd_in_range),
        .rd_addr (cmd_col),
        .rd_data (rd_word)
    );

    vgh_fill #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_restart),
        .size_x  (size_x_reg),
        .size_y  (size_y_reg),
        .size_z  (size_z_reg),
        .busy    (fill_busy),
        .wr_en   (fill_wr_en),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data)
    );

    vgh_scan #(
        .MAX_Y (MAX_Y)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .word  (new_word & below_mask),
        .rsp   (scan_rsp)
    );

    // A size write always leaves the refill sweep running on the next cycle.
    a_restart_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_restart |=> fill_busy)
        else $error("size write did not start the ground refill");

    // The height search only reports while the sequencer waits for it.
    a_scan_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_rsp.done |-> (state_reg == S_SCAN))
        else $error("height search finished outside the search state");

    // An accepted beat always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> (state_reg != S_IDLE))
        else $error("command beat accepted but sequencer stayed idle");

    // A tile write never collides with the refill sweep.
    a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_wr_en |-> !fill_busy)
        else $error("tile write during ground refill");

endmodule

`default_nettype wire

FILE: dv/voxel_grid_with_column_heightmap_top_tb.sv
`default_nettype none

module voxel_grid_with_column_heightmap_top_tb;
    import vgh_pkg::*;

    localparam int GRID_MAX_X = 64;
    localparam int GRID_MAX_Y = 64;
    localparam int GRID_MAX_Z = 64;
    localparam int NUM_COLUMNS = GRID_MAX_X * GRID_MAX_Z;

    // Query codes; only the set code lives in the package.
    localparam logic [CMD_W-1:0] CMD_QUERY_TILE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY_SHADOW = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED       = 2'd3;

    // Register index past the end of the register list.
    localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

    localparam int IDLE_PERCENT  = 15;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 16;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_stall;
    cmd_beat_t         cmd_beat = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    rsp_beat_t         rsp_beat;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    // Testbench control.
    cmd_beat_t cmd_backlog[$];
    rsp_beat_t expected_voxel_rsp[$];
    bit        tx_idle_on = 1'b1;
    bit        rx_idle_on = 1'b1;
    bit        hold_trigger = 1'b0;
    int        hold_left = 0;
    int        quiet_cycles = 0;
    int        error_count = 0;
    int        rsp_count = 0;

    // Mirror of the grid: one occupancy word per (x, z) column, plus the sizes.
    logic [GRID_MAX_Y-1:0] occ_map [NUM_COLUMNS];
    int grid_x;
    int grid_y;
    int grid_z;

    voxel_grid_with_column_heightmap_top #(
        .MAX_X (GRID_MAX_X),
        .MAX_Y (GRID_MAX_Y),
        .MAX_Z (GRID_MAX_Z)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_beat  (cmd_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Highest solid y in [1, top] of a column word, or 0 if there is none.
    function automatic int top_solid(logic [GRID_MAX_Y-1:0] word, int top);
        for (int y = top; y > 0; y--)
        begin
            if (word[y])
                return y;
        end
        return 0;
    endfunction

    // Ground fill: solid up to two thirds of the height inside the sizes.
    function automatic void fill_ground();
        int ground;
        logic [GRID_MAX_Y-1:0] word;
        ground = (2 * grid_y) / 3;
        for (int z = 0; z < GRID_MAX_Z; z++)
        begin
            for (int x = 0; x < GRID_MAX_X; x++)
            begin
                word = '0;
                if (x < grid_x && z < grid_z)
                begin
                    for (int y = 0; y < grid_y; y++)
                    begin
                        if (y <= ground)
                            word[y] = 1'b1;
                    end
                end
                occ_map[x + z * GRID_MAX_X] = word;
            end
        end
    endfunction

    function automatic int clamp_size(int value, int max_value);
        if (value < 1)
            return 1;
        if (value > max_value)
            return max_value;
        return value;
    endfunction

    // A size write clamps the value and refills the grid; other indexes do nothing.
    function automatic void apply_size_write(logic [IDX_W-1:0] index, int value);
        if (index == REG_SIZE_X)
            grid_x = clamp_size(value, GRID_MAX_X);
        else if (index == REG_SIZE_Y)
            grid_y = clamp_size(value, GRID_MAX_Y);
        else if (index == REG_SIZE_Z)
            grid_z = clamp_size(value, GRID_MAX_Z);
        else
            return;
        fill_ground();
    endfunction

    // Applies one command to the mirror and returns the result beat it should give.
    function automatic rsp_beat_t apply_voxel_cmd(cmd_beat_t b);
        rsp_beat_t r;
        int col;
        logic [GRID_MAX_Y-1:0] word;
        r = '0;
        if (b.pos_x >= grid_x || b.pos_y >= grid_y || b.pos_z >= grid_z)
            return r;
        col = b.pos_x + b.pos_z * GRID_MAX_X;
        if (b.command == CMD_SET)
        begin
            occ_map[col][b.pos_y] = (b.tile_type != '0);
            r.dirty_x_low = (b.pos_x == '0) ? '0 : b.pos_x - 1'b1;
            r.dirty_z_low = (b.pos_z == '0) ? '0 : b.pos_z - 1'b1;
            if (b.pos_y != '0)
                r.dirty_y_low = COORD_W'(top_solid(occ_map[col], b.pos_y - 1));
        end
        word = occ_map[col];
        r.in_range = 1'b1;
        r.is_tile = word[b.pos_y];
        r.is_dark = (b.pos_y < top_solid(word, grid_y - 1));
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("result beat %0d field %s: got %0d, expected %0d",
                                      rsp_count, name, got, want));
    endtask

    // Command driver: a new beat is offered only once the previous one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_beat <= '0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            if (cmd_backlog.size() != 0 &&
                !(tx_idle_on && $urandom_range(99) < IDLE_PERCENT))
            begin
                cmd_valid <= 1'b1;
                cmd_beat <= cmd_backlog.pop_front();
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_trigger)
        begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            rsp_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Every accepted command beat yields exactly one expected result.
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
            expected_voxel_rsp.push_back(apply_voxel_cmd(cmd_beat));
    end

    // Result checker.
    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_voxel_rsp.size() == 0)
            begin
                report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                          rsp_count));
            end
            else
            begin
                want = expected_voxel_rsp.pop_front();
                check_field("in_range", rsp_beat.in_range, want.in_range);
                check_field("is_tile", rsp_beat.is_tile, want.is_tile);
                check_field("is_dark", rsp_beat.is_dark, want.is_dark);
                check_field("dirty_x_low", rsp_beat.dirty_x_low, want.dirty_x_low);
                check_field("dirty_y_low", rsp_beat.dirty_y_low, want.dirty_y_low);
                check_field("dirty_z_low", rsp_beat.dirty_z_low, want.dirty_z_low);
            end
            rsp_count++;
        end
    end

    // Watchdog on cycles without any accepted beat or register write.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic push_cmd(logic [CMD_W-1:0] command, int x, int y, int z, int tile);
        cmd_beat_t b;
        b.command = command;
        b.pos_x = COORD_W'(x);
        b.pos_y = COORD_W'(y);
        b.pos_z = COORD_W'(z);
        b.tile_type = TILE_W'(tile);
        cmd_backlog.push_back(b);
    endtask

    // Mostly inside the configured size, sometimes anywhere in the field.
    function automatic int pick_coord(int size);
        if ($urandom_range(99) < 85)
            return $urandom_range(size - 1);
        return $urandom_range(63);
    endfunction

    task automatic queue_random_cmds(int count);
        int roll;
        int x;
        int z;
        logic [CMD_W-1:0] command;
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
                command = CMD_SET;
            else if (roll < 65)
                command = CMD_QUERY_TILE;
            else if (roll < 90)
                command = CMD_QUERY_SHADOW;
            else
                command = CMD_UNUSED;
            // Half the beats hit a few columns so that their light depth moves a lot.
            if ($urandom_range(1) == 0)
            begin
                x = $urandom_range(((grid_x < 3) ? grid_x : 3) - 1);
                z = $urandom_range(((grid_z < 3) ? grid_z : 3) - 1);
            end
            else
            begin
                x = pick_coord(grid_x);
                z = pick_coord(grid_z);
            end
            push_cmd(command, x, pick_coord(grid_y), z,
                     ($urandom_range(99) < 30) ? 0 : $urandom_range(255, 1));
        end
    endtask

    // Waits until every queued beat is sent and every result has come back.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || cmd_valid || expected_voxel_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_size_reg(logic [IDX_W-1:0] index, int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= CFG_W'(value);
        apply_size_write(index, value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One size setting: write, batch, drain, optional hold-off or no idles, batch.
    task automatic run_phase(logic [IDX_W-1:0] index, int value, int count,
                             bit hold_off, bit no_idle);
        wait_drained();
        write_size_reg(index, value);
        queue_random_cmds(count / 2);
        wait_drained();
        if (no_idle)
        begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
        end
        if (hold_off)
        begin
            hold_trigger = 1'b1;
            @(negedge clk);
            hold_trigger = 1'b0;
        end
        queue_random_cmds(count - count / 2);
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        grid_x = SIZE_RESET;
        grid_y = SIZE_RESET;
        grid_z = SIZE_RESET;
        fill_ground();

        // Directed beats at the reset sizes, where the ground reaches y = 42.
        push_cmd(CMD_SET, 0, 63, 0, 255);
        push_cmd(CMD_QUERY_SHADOW, 0, 62, 0, 0);
        push_cmd(CMD_QUERY_TILE, 0, 0, 0, 0);
        push_cmd(CMD_SET, 0, 63, 0, 0);
        push_cmd(CMD_QUERY_SHADOW, 0, 42, 0, 0);
        push_cmd(CMD_SET, 63, 0, 63, 0);
        push_cmd(CMD_SET, 63, 1, 63, 0);
        push_cmd(CMD_QUERY_TILE, 63, 63, 63, 255);
        push_cmd(CMD_SET, 10, 42, 20, 0);
        push_cmd(CMD_QUERY_SHADOW, 10, 41, 20, 0);
        push_cmd(CMD_QUERY_SHADOW, 10, 40, 20, 0);
        push_cmd(CMD_SET, 1, 50, 1, 128);
        push_cmd(CMD_UNUSED, 1, 50, 1, 170);
        push_cmd(CMD_SET, 32, 21, 16, 85);
        push_cmd(CMD_SET, 42, 63, 21, 1);
        push_cmd(CMD_QUERY_SHADOW, 42, 0, 21, 0);
        push_cmd(CMD_SET, 7, 2, 7, 0);
        push_cmd(CMD_SET, 7, 1, 7, 0);
        push_cmd(CMD_SET, 7, 3, 7, 0);
        push_cmd(CMD_QUERY_SHADOW, 7, 2, 7, 0);
        push_cmd(CMD_SET, 5, 10, 5, 0);
        push_cmd(CMD_SET, 5, 11, 5, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_random_cmds(60);

        // Sizes walk through clamped extremes, small grids and an ignored index.
        run_phase(REG_SIZE_Y, 0, 40, 1'b0, 1'b0);
        run_phase(REG_SIZE_X, 5, 50, 1'b0, 1'b0);
        run_phase(REG_SIZE_Z, 127, 50, 1'b0, 1'b0);
        run_phase(REG_SIZE_Y, 127, 60, 1'b1, 1'b0);
        run_phase(REG_SIZE_X, 0, 40, 1'b0, 1'b0);
        run_phase(REG_NONE, 5, 40, 1'b0, 1'b0);
        run_phase(REG_SIZE_Z, 1, 40, 1'b0, 1'b0);
        run_phase(REG_SIZE_X, 64, 60, 1'b0, 1'b1);
        run_phase(REG_SIZE_Y, 10, 60, 1'b0, 1'b0);
        run_phase(REG_SIZE_Z, 64, 60, 1'b1, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_voxel_rsp.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_voxel_rsp.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
